@@ rtl/core/fsise_pkg.sv @@
// Shared constants for the full search image shift estimator.
// No dependencies; imported by the top level.
package fsise_pkg;

  // Default size limits, handed to the top level parameters.
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_RANGE_DEF  = 8;

  // Field widths.
  localparam int PIX_W      = 16;
  localparam int SHIFT_W    = 4;
  localparam int CFG_DIM_W  = 7;
  localparam int CFG_RNG_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 2 * PIX_W;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * SHIFT_W - 2;

  // Squared difference of two 16-bit pixels fits 32 bits unsigned.
  localparam int SQ_W = 32;

  // Pixel value that marks missing data.
  localparam logic signed [PIX_W-1:0] NO_DATA = 16'sd5000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = 2'd2;

endpackage

@@ rtl/core/full_search_image_shift_estimator.sv @@
// Top level of the full search image shift estimator: frame stores,
// shift sequencer, squared-difference pipe. Uses fsise_pkg and fsise_xmul.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tdata: pixel_ref, pixel_moved; s_tlast: frame_end
// m_*       out  m_tvalid / m_tready  m_tdata: shift_x, shift_y, match_found, length_error
// cfg_*     in   cfg_we               cfg_addr: register index; cfg_wdata: value
//
// Cycles: pixel pairs load at one per cycle while s_tready is high. After a
// full frame the search scores (2*r-1)^2 shifts for r = search_range, each
// read through the single read port of each frame store into one squared-difference
// path, with the shift-add compare unit run for each shift scored against an earlier best.
// A frame of wrong length answers at once with the error flag.
// Reset: rst clears control state and the configuration registers; the frame stores are not cleared.
// Stalls: input is held off during a search and while a result waits in m_*.
module full_search_image_shift_estimator import fsise_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RANGE  = MAX_RANGE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] pixel_ref, [31:16] pixel_moved
  input  logic                  s_tlast,   // frame_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] shift_x, [7:4] shift_y,
                                           // [8] match_found, [9] length_error
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DIM_W-1:0]  cfg_wdata
);

  localparam int CAP  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int LW   = $clog2(CAP + 2);
  localparam int CW   = $clog2(CAP + 1);
  localparam int SUMW = SQ_W + ((CAP > 1) ? $clog2(CAP) : 0);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RNW  = $clog2(MAX_RANGE + 1);
  localparam int SHW  = $clog2(MAX_RANGE) + 1;
  localparam int OFFW = SHW + WW + 2;
  localparam int MVW  = AW + OFFW + 1;
  localparam int CMPW = ((WW > HW) ? WW : HW) + SHW + 2;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_CMP    = 3'd5;
  localparam logic [2:0] ST_NEXT   = 3'd6;

  // Configuration registers.
  logic [CFG_DIM_W-1:0] frame_width;
  logic [CFG_DIM_W-1:0] frame_height;
  logic [CFG_RNG_W-1:0] search_range;

  // Sequencer and frame geometry latched at frame end.
  logic [2:0]            state;
  logic [LW-1:0]         load_index;
  logic [WW-1:0]         wr;
  logic [HW-1:0]         hr;
  logic signed [SHW-1:0] rm1;
  logic signed [SHW-1:0] sx;
  logic signed [SHW-1:0] sy;
  logic signed [OFFW-1:0] off;
  logic [HW-1:0]         row;
  logic [WW-1:0]         col;
  logic [AW-1:0]         p;

  // Frame stores.
  logic [PIX_W-1:0] ref_mem [CAP];
  logic [PIX_W-1:0] mv_mem  [CAP];

  // Pipe stages.
  logic             v1, v2, v3;
  logic             inb1, ok2, ok3;
  logic [PIX_W-1:0] rd_ref, rd_mv;
  logic [PIX_W-1:0] ad2;
  logic [SQ_W-1:0]  sq3;
  logic [SUMW-1:0]  acc_sum;
  logic [CW-1:0]    acc_cnt;

  // Best score so far.
  logic [SUMW-1:0]       best_sum;
  logic [CW-1:0]         best_count;
  logic signed [SHW-1:0] bx;
  logic signed [SHW-1:0] by;

  // Result register.
  logic               out_match;
  logic               out_err;
  logic [SHIFT_W-1:0] out_x;
  logic [SHIFT_W-1:0] out_y;

  logic cmp_start;
  logic cmp_done;
  logic cmp_less;

  // Combinational helpers.
  logic                   in_acc;
  logic [LW-1:0]          load_next;
  logic [WW-1:0]          w_cl;
  logic [HW-1:0]          h_cl;
  logic [RNW-1:0]         r_cl;
  logic signed [SHW-1:0]  rm1_now;
  logic [LW-1:0]          wh_now;
  logic signed [OFFW-1:0] off_next;
  logic signed [CMPW-1:0] sr_c;
  logic signed [CMPW-1:0] sc_c;
  logic                   inb0;
  logic signed [MVW-1:0]  mv_full;
  logic [AW-1:0]          mv_addr;
  logic signed [PIX_W:0]  d1;
  logic signed [PIX_W:0]  ad1;
  logic                   last_pix;
  logic                   last_shift;
  logic                   pipe_empty;
  logic signed [SHW:0]    nbx;
  logic signed [SHW:0]    nby;
  logic                   out_load;

  assign s_tready = (state == ST_LOAD) && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;
  assign m_tdata  = {OUT_PAD_W'(0), out_err, out_match, out_y, out_x};

  // Clamp the registers into their legal ranges.
  always_comb begin
    if (frame_width == '0) begin
      w_cl = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_cl = HW'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_cl = HW'(MAX_HEIGHT);
    end else begin
      h_cl = HW'(frame_height);
    end
    if (search_range == '0) begin
      r_cl = RNW'(1);
    end else if (32'(search_range) > 32'(MAX_RANGE)) begin
      r_cl = RNW'(MAX_RANGE);
    end else begin
      r_cl = RNW'(search_range);
    end
  end

  assign rm1_now   = SHW'(r_cl - RNW'(1));
  assign wh_now    = LW'(w_cl) * LW'(h_cl);
  assign load_next = (load_index <= LW'(CAP)) ? load_index + LW'(1) : load_index;

  // Linear offset of the current shift in the moved frame.
  assign off_next = OFFW'(sy) * OFFW'($signed({1'b0, wr})) + OFFW'(sx);

  // Source position of the current pixel and its bounds test.
  assign sr_c = CMPW'($signed({1'b0, row})) - CMPW'(sy);
  assign sc_c = CMPW'($signed({1'b0, col})) - CMPW'(sx);
  assign inb0 = !sr_c[CMPW-1] && (sr_c < CMPW'($signed({1'b0, hr})))
             && !sc_c[CMPW-1] && (sc_c < CMPW'($signed({1'b0, wr})));
  assign mv_full = MVW'($signed({1'b0, p})) - MVW'(off);
  assign mv_addr = mv_full[AW-1:0];

  assign last_pix   = (row == hr - HW'(1)) && (col == wr - WW'(1));
  assign last_shift = (sx == rm1) && (sy == rm1);
  assign pipe_empty = !v1 && !v2 && !v3;

  assign d1  = $signed({rd_ref[PIX_W-1], rd_ref}) - $signed({rd_mv[PIX_W-1], rd_mv});
  assign ad1 = d1[PIX_W] ? -d1 : d1;

  assign nbx = -(SHW + 1)'(bx);
  assign nby = -(SHW + 1)'(by);

  assign cmp_start = (state == ST_DECIDE) && (acc_cnt != '0) && (best_count != '0);

  // A new result is loaded this cycle: wrong-length frame end or end of search.
  assign out_load = (in_acc && s_tlast && (load_next != wh_now))
                 || ((state == ST_NEXT) && last_shift);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DIM_W'(64);
      frame_height <= CFG_DIM_W'(64);
      search_range <= CFG_RNG_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        REG_SEARCH_RANGE: search_range <= cfg_wdata[CFG_RNG_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame stores: write while loading, one read per store while scanning.
  always_ff @(posedge clk) begin
    if (in_acc && (load_index < LW'(CAP))) begin
      ref_mem[load_index[AW-1:0]] <= s_tdata[PIX_W-1:0];
      mv_mem[load_index[AW-1:0]]  <= s_tdata[IN_DATA_W-1:PIX_W];
    end
    rd_ref <= ref_mem[p];
    rd_mv  <= mv_mem[mv_addr];
  end

  // Squared-difference pipe: read, difference, square, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      ok3 <= 1'b0;
    end else begin
      v1  <= (state == ST_SCAN);
      v2  <= v1;
      v3  <= v2;
      ok3 <= v2 && ok2;
    end
  end

  always_ff @(posedge clk) begin
    inb1 <= inb0;
    ok2  <= inb1 && (rd_ref != NO_DATA) && (rd_mv != NO_DATA);
    ad2  <= ad1[PIX_W-1:0];
    sq3  <= ad2 * ad2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum <= '0;
      acc_cnt <= '0;
    end else if (state == ST_SETUP) begin
      acc_sum <= '0;
      acc_cnt <= '0;
    end else if (ok3) begin
      acc_sum <= acc_sum + SUMW'(sq3);
      acc_cnt <= acc_cnt + CW'(1);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_index <= '0;
      m_tvalid   <= 1'b0;
      best_sum   <= '0;
      best_count <= '0;
      bx         <= '0;
      by         <= '0;
      wr         <= WW'(1);
      hr         <= HW'(1);
      rm1        <= '0;
      sx         <= '0;
      sy         <= '0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            load_index <= s_tlast ? '0 : load_next;
            if (s_tlast) begin
              if (load_next != wh_now) begin
                // Wrong frame length: answer at once, no search.
                m_tvalid  <= 1'b1;
                out_x     <= '0;
                out_y     <= '0;
                out_match <= 1'b0;
                out_err   <= 1'b1;
              end else begin
                wr         <= w_cl;
                hr         <= h_cl;
                rm1        <= rm1_now;
                sx         <= -rm1_now;
                sy         <= -rm1_now;
                best_sum   <= '0;
                best_count <= '0;
                bx         <= '0;
                by         <= '0;
                state      <= ST_SETUP;
              end
            end
          end
        end
        ST_SETUP: begin
          off   <= off_next;
          row   <= '0;
          col   <= '0;
          p     <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          p <= p + AW'(1);
          if (col == wr - WW'(1)) begin
            col <= '0;
            row <= row + HW'(1);
          end else begin
            col <= col + WW'(1);
          end
          if (last_pix) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (acc_cnt == '0) begin
            state <= ST_NEXT;
          end else if (best_count == '0) begin
            best_sum   <= acc_sum;
            best_count <= acc_cnt;
            bx         <= sx;
            by         <= sy;
            state      <= ST_NEXT;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (cmp_done) begin
            // Keep the earlier shift on a tie.
            if (cmp_less) begin
              best_sum   <= acc_sum;
              best_count <= acc_cnt;
              bx         <= sx;
              by         <= sy;
            end
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (last_shift) begin
            m_tvalid  <= 1'b1;
            out_x     <= SHIFT_W'(nbx);
            out_y     <= SHIFT_W'(nby);
            out_match <= (best_count != '0);
            out_err   <= 1'b0;
            state     <= ST_LOAD;
          end else begin
            if (sy == rm1) begin
              sy <= -rm1;
              sx <= sx + SHW'(1);
            end else begin
              sy <= sy + SHW'(1);
            end
            state <= ST_SETUP;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  fsise_xmul #(
    .SUMW (SUMW),
    .CW   (CW)
  ) u_xmul (
    .clk   (clk),
    .rst   (rst),
    .start (cmp_start),
    .sum_a (acc_sum),
    .cnt_a (acc_cnt),
    .sum_b (best_sum),
    .cnt_b (best_count),
    .done  (cmp_done),
    .less  (cmp_less)
  );

`ifndef ASSERT_OFF
  // The result register is free while the frame is scanned.
  a_out_free_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !m_tvalid)
    else $error("result pending during scan");

  // A result appears only after a frame end or at the end of a search.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_NEXT) || $past(s_tvalid && s_tready && s_tlast))
    else $error("result without frame end or search end");

  // The compare unit answers only while the sequencer waits for it.
  a_cmp_done_state: assert property (@(posedge clk) disable iff (rst)
    cmp_done |-> (state == ST_CMP))
    else $error("compare done outside compare wait");

  // The pair counter saturates one above capacity.
  a_load_sat: assert property (@(posedge clk) disable iff (rst)
    load_index <= LW'(CAP + 1))
    else $error("load index beyond saturation");
`endif

endmodule

@@ rtl/core/fsise_xmul.sv @@
// Bit-serial cross-product compare: is sum_a*cnt_b < sum_b*cnt_a ?
// Stand-alone shift-add unit, no package needed.
module fsise_xmul #(
  parameter int SUMW = 44,
  parameter int CW   = 13
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SUMW-1:0] sum_a,
  input  logic [CW-1:0]   cnt_a,
  input  logic [SUMW-1:0] sum_b,
  input  logic [CW-1:0]   cnt_b,
  output logic            done,
  output logic            less
);

  localparam int PW  = SUMW + CW;
  localparam int STW = $clog2(CW + 1);

  logic [PW-1:0]  ma;
  logic [PW-1:0]  mb;
  logic [PW-1:0]  pa;
  logic [PW-1:0]  pb;
  logic [CW-1:0]  qa;
  logic [CW-1:0]  qb;
  logic [STW-1:0] step;
  logic           busy;

  // One multiplier bit per cycle on both products.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == STW'(CW - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STW'(1);
        if (step == STW'(CW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma <= PW'(sum_a);
      mb <= PW'(sum_b);
      qa <= cnt_b;
      qb <= cnt_a;
      pa <= '0;
      pb <= '0;
    end else if (busy) begin
      if (qa[0]) begin
        pa <= pa + ma;
      end
      if (qb[0]) begin
        pb <= pb + mb;
      end
      ma <= ma << 1;
      mb <= mb << 1;
      qa <= qa >> 1;
      qb <= qb >> 1;
    end
  end

  assign less = (pa < pb);

endmodule
